### src/assert_macros.svh
// Assertion macros shared by the slicer threshold RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define OAST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define OAST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/oast_pkg.sv
// Package for the OOK adaptive slicer threshold: widths, reset values,
// register indexes and the bound-pair type. No dependencies.
`timescale 1ns / 1ps

package oast_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int BOUND_BITS     = 19;
   localparam int STEP_BITS      = 14;
   localparam int RANGE_BITS     = 15;
   localparam int OUT_BITS       = 17;
   localparam int CSR_DATA_BITS  = 15;
   localparam int CSR_INDEX_BITS = 1;

   localparam int WIDE_BITS = (SAMPLE_BITS > BOUND_BITS) ? SAMPLE_BITS : BOUND_BITS;
   localparam int WORK_BITS = WIDE_BITS + 3;
   localparam int TH_BITS   = BOUND_BITS + 2;

   localparam int OUT_MAX = 2 ** (OUT_BITS - 1) - 1;
   localparam int OUT_MIN = -(2 ** (OUT_BITS - 1));

   localparam logic [BOUND_BITS-1:0] LOW_RESET   = '1;
   localparam logic [BOUND_BITS-1:0] HIGH_RESET  = BOUND_BITS'(1);
   localparam logic [STEP_BITS-1:0]  STEP_RESET  = STEP_BITS'(1);
   localparam logic [RANGE_BITS-1:0] RANGE_RESET = RANGE_BITS'(3);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BOUND_STEP   = 1'b0,
      CSR_SPREAD_FLOOR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                  valid;
      logic [BOUND_BITS-1:0] low;
      logic [BOUND_BITS-1:0] high;
   } bounds_type;

endpackage

### src/oast_req_if.sv
// Sample channel: valid/ready plus one signed envelope sample per beat.
// Depends on oast_pkg.
`timescale 1ns / 1ps

interface oast_req_if;
   import oast_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

### src/oast_rsp_if.sv
// Threshold channel: valid/ready plus the mid and low thresholds per beat.
// Depends on oast_pkg.
`timescale 1ns / 1ps

interface oast_rsp_if;
   import oast_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] mid_threshold;
   logic signed [OUT_BITS-1:0] low_threshold;

   modport source (output valid, output mid_threshold, output low_threshold, input ready);
   modport sink   (input valid, input mid_threshold, input low_threshold, output ready);
endinterface

### src/oast_update.sv
// Input register and combinational peak/valley bound update.
// Depends on oast_pkg, oast_req_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module oast_update (
   input  logic                            clock,
   input  logic                            reset,
   oast_req_if.sink                        req,
   input  logic [oast_pkg::STEP_BITS-1:0]  bound_step,
   input  logic [oast_pkg::RANGE_BITS-1:0] spread_floor,
   output oast_pkg::bounds_type            pend,
   input  logic                            pend_ready
);
   import oast_pkg::*;

   logic                          in_valid_ff, in_valid_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          pend_valid_ff, pend_valid_in;
   logic [BOUND_BITS-1:0]         low_bound_ff, low_bound_in;
   logic [BOUND_BITS-1:0]         high_bound_ff, high_bound_in;

   logic pend_load;
   logic upd_fire;
   logic in_load;

   logic signed [WORK_BITS-1:0] s_w, lo0, hi0, lo1, hi1, lo2, hi2;
   logic signed [WORK_BITS-1:0] spread1, mid1, range_w, step_w;
   logic                        decay_en;

   assign pend_load = !pend_valid_ff || pend_ready;
   assign upd_fire  = in_valid_ff && pend_load;
   assign req.ready = !in_valid_ff || pend_load;
   assign in_load   = req.valid && req.ready;

   assign in_valid_in   = in_load || (in_valid_ff && !pend_load);
   assign pend_valid_in = upd_fire || (pend_valid_ff && !pend_ready);

   always_comb begin
      s_w     = {{(WORK_BITS-SAMPLE_BITS){sample_ff[SAMPLE_BITS-1]}}, sample_ff};
      lo0     = {{(WORK_BITS-BOUND_BITS){low_bound_ff[BOUND_BITS-1]}}, low_bound_ff};
      hi0     = {{(WORK_BITS-BOUND_BITS){high_bound_ff[BOUND_BITS-1]}}, high_bound_ff};
      range_w = $signed({{(WORK_BITS-RANGE_BITS){1'b0}}, spread_floor});
      step_w  = $signed({{(WORK_BITS-STEP_BITS){1'b0}}, bound_step});

      lo1 = (s_w < lo0) ? s_w : lo0;
      hi1 = (s_w > hi0) ? s_w : hi0;

      spread1  = hi1 - lo1;
      mid1     = lo1 + (spread1 >>> 1);
      decay_en = (hi1 > lo1) && (spread1 >= range_w);

      lo2 = lo1;
      hi2 = hi1;
      if (decay_en) begin
         if (s_w > mid1) begin
            hi2 = hi1 - step_w;
         end else begin
            lo2 = lo1 + step_w;
         end
         if (lo2 > hi2) begin
            hi2 = lo2 + range_w + step_w;
         end
      end

      low_bound_in  = upd_fire ? lo2[BOUND_BITS-1:0] : low_bound_ff;
      high_bound_in = upd_fire ? hi2[BOUND_BITS-1:0] : high_bound_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         low_bound_ff  <= LOW_RESET;
         high_bound_ff <= HIGH_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         pend_valid_ff <= pend_valid_in;
         low_bound_ff  <= low_bound_in;
         high_bound_ff <= high_bound_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         sample_ff <= req.sample;
      end
   end

   // bounds seen by the threshold stage are the state after the pending beat
   assign pend.valid = pend_valid_ff;
   assign pend.low   = low_bound_ff;
   assign pend.high  = high_bound_ff;

   `OAST_ASSERT_ALWAYS(a_bounds_reset, clock, reset |=> (low_bound_ff == LOW_RESET && high_bound_ff == HIGH_RESET), "bounds not restored by reset")
   `OAST_ASSERT(a_bounds_hold, clock, reset, !upd_fire |=> ($stable(low_bound_ff) && $stable(high_bound_ff)), "bounds moved without a sample")

endmodule

### src/oast_thresh.sv
// Threshold stage: midpoint and quarter point of the tracked bounds,
// saturated and held in the result register. Depends on oast_pkg,
// oast_rsp_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module oast_thresh (
   input  logic                 clock,
   input  logic                 reset,
   input  oast_pkg::bounds_type pend,
   output logic                 pend_ready,
   oast_rsp_if.source           rsp
);
   import oast_pkg::*;

   function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [TH_BITS-1:0] x);
      logic [OUT_BITS-1:0] r;
      if (x > OUT_MAX) begin
         r = OUT_BITS'(OUT_MAX);
      end else if (x < OUT_MIN) begin
         r = OUT_BITS'(OUT_MIN);
      end else begin
         r = x[OUT_BITS-1:0];
      end
      return r;
   endfunction

   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] rsp_mid_ff, rsp_low_ff;
   logic                rsp_load;

   logic signed [TH_BITS-1:0] lo_w, hi_w, spread, half, quarter;
   logic [1:0]                bias;

   assign rsp_load     = !rsp_valid_ff || rsp.ready;
   assign pend_ready   = rsp_load;
   assign rsp_valid_in = pend.valid || (rsp_valid_ff && !rsp.ready);

   // divisions truncate toward zero: bias negative spreads before the shift
   always_comb begin
      lo_w    = {{(TH_BITS-BOUND_BITS){pend.low[BOUND_BITS-1]}}, pend.low};
      hi_w    = {{(TH_BITS-BOUND_BITS){pend.high[BOUND_BITS-1]}}, pend.high};
      spread  = hi_w - lo_w;
      bias    = {2{spread[TH_BITS-1]}};
      half    = (spread + $signed({{(TH_BITS-1){1'b0}}, bias[0]})) >>> 1;
      quarter = (spread + $signed({{(TH_BITS-2){1'b0}}, bias})) >>> 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && pend.valid) begin
         rsp_mid_ff <= sat_out(lo_w + half);
         rsp_low_ff <= sat_out(lo_w + quarter);
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.mid_threshold = rsp_mid_ff;
   assign rsp.low_threshold = rsp_low_ff;

   `OAST_ASSERT(a_rsp_from_pend, clock, reset, $rose(rsp_valid_ff) |-> $past(pend.valid), "result appeared without pending bounds")
   `OAST_ASSERT(a_pend_taken, clock, reset, (pend.valid && rsp_load) |=> rsp_valid_ff, "pending bounds dropped")

endmodule

### src/ook_adaptive_slicer_threshold_core.sv
// Top level of the OOK adaptive slicer threshold: configuration registers,
// bound tracker and threshold stage. Depends on oast_pkg, oast_req_if,
// oast_rsp_if, oast_update and oast_thresh.
`timescale 1ns / 1ps

// Tracks the peak and valley of a signed envelope and returns, for each
// sample beat, the midpoint slicing threshold and a lower hysteresis
// threshold (valley plus a quarter of the spread), both saturated to 17 bits.
// One sample is taken every clock while the pipe is not stalled; the sample
// passes the input register, the bound registers and the result register
// in turn. The rate is set by the bound update, a compare/add/select loop
// on the stored bounds. Backpressure on the result side stalls the pipe one
// stage at a time. Write bound_step (index 0) and spread_floor (index 1)
// only while no beats are in flight; keep spread_floor above twice
// bound_step. Reset values: bounds -1/+1, bound_step 1, spread_floor 3.
module ook_adaptive_slicer_threshold_core (
   input  logic                                clock,
   input  logic                                reset,
   oast_req_if.sink                            req_bus,
   oast_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [oast_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [oast_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import oast_pkg::*;

   logic [STEP_BITS-1:0]  bound_step_ff, bound_step_in;
   logic [RANGE_BITS-1:0] spread_floor_ff, spread_floor_in;
   bounds_type            pend;
   logic                  pend_ready;

   always_comb begin
      bound_step_in   = bound_step_ff;
      spread_floor_in = spread_floor_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BOUND_STEP:   bound_step_in   = csr_wdata[STEP_BITS-1:0];
            CSR_SPREAD_FLOOR: spread_floor_in = csr_wdata[RANGE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_step_ff   <= STEP_RESET;
         spread_floor_ff <= RANGE_RESET;
      end else begin
         bound_step_ff   <= bound_step_in;
         spread_floor_ff <= spread_floor_in;
      end
   end

   oast_update u_update (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .bound_step   (bound_step_ff),
      .spread_floor (spread_floor_ff),
      .pend         (pend),
      .pend_ready   (pend_ready)
   );

   oast_thresh u_thresh (
      .clock      (clock),
      .reset      (reset),
      .pend       (pend),
      .pend_ready (pend_ready),
      .rsp        (rsp_bus)
   );

endmodule
